// File: hdl/tpsr_pkg.sv
// Shared types and constants of the trapezoid profile stepper rate unit.
// No dependencies; the top level, tpsr_seq and the bench refer to it by scoped names.
package tpsr_pkg;

  localparam int unsigned DIV_W = 64;

  localparam logic [2:0] REG_ACCEL    = 3'd0;
  localparam logic [2:0] REG_START    = 3'd1;
  localparam logic [2:0] REG_MAX      = 3'd2;
  localparam logic [2:0] REG_END      = 3'd3;
  localparam logic [2:0] REG_DISTANCE = 3'd4;
  localparam logic [2:0] REG_MODE     = 3'd5;
  localparam logic [2:0] REG_CENTRE   = 3'd6;
  localparam logic [2:0] REG_DIAMETER = 3'd7;

  localparam logic [2:0] MODE_FWD_WALL  = 3'd1;
  localparam logic [2:0] MODE_BACK      = 3'd2;
  localparam logic [2:0] MODE_BACK_WALL = 3'd3;
  localparam logic [2:0] MODE_TURN_L    = 3'd4;
  localparam logic [2:0] MODE_TURN_R    = 3'd5;

  localparam logic [1:0] PH_ACCEL  = 2'd0;
  localparam logic [1:0] PH_CRUISE = 2'd1;
  localparam logic [1:0] PH_BRAKE  = 2'd2;

  localparam logic [31:0] TURN_MUL     = 32'd10289152;  // 157 * 65536
  localparam logic [63:0] TURN_ROUND   = 64'd4500;
  localparam logic [63:0] TURN_DIV     = 64'd9000;
  localparam logic [31:0] PERIOD_K     = 32'd157;
  localparam logic [15:0] PERIOD_START = 16'd10000;
  localparam logic [15:0] PERIOD_SLOW  = 16'd65534;
  localparam logic [15:0] PERIOD_LIM   = 16'hFFFF;

  localparam logic [15:0] RST_ACCEL    = 16'd3000;
  localparam logic [11:0] RST_START    = 12'd500;
  localparam logic [11:0] RST_MAX      = 12'd500;
  localparam logic [11:0] RST_END      = 12'd500;
  localparam logic [15:0] RST_DISTANCE = 16'd160;
  localparam logic [2:0]  RST_MODE     = 3'd0;
  localparam logic [11:0] RST_CENTRE   = 12'd0;
  localparam logic [15:0] RST_DIAMETER = 16'd51115;

  typedef struct packed {
    logic [15:0] accel;
    logic [11:0] start_speed;
    logic [11:0] max_speed;
    logic [11:0] end_speed;
    logic [15:0] distance;
    logic [2:0]  motion_mode;
    logic [11:0] centre_speed;
    logic [15:0] wheel_diameter;
  } cfg_t;

  typedef struct packed {
    logic        moving;
    logic        right_dir;
    logic        left_dir;
    logic [15:0] right_period;
    logic [15:0] left_period;
  } res_t;

endpackage

// File: hdl/trapezoid_profile_stepper_rates_unit.sv
// Top level: configuration registers, stream ports and output register.
// Depends on tpsr_pkg and tpsr_seq.
//
//  channel   dir  fields
//  s_axis    in   tuser: operation; tdata: wall_correction
//  m_axis    out  tdata: left/right period, left/right dir, moving
//  cfg       in   cfg_we_i, cfg_idx_i, cfg_wdata_i
//
// A turn start scales each register by division; a start with zero accel skips the
// brake division. The tick that ends the move skips the speed division, and a tick
// with a zero wheel speed skips both period divisions.
// One word is in flight at a time; a finished word waits in the output register
// while the next input is taken. Reset loads the register defaults.
module trapezoid_profile_stepper_rates_unit #(
  parameter int unsigned TREAD_WIDTH      = 84,
  parameter int unsigned TICKS_PER_SECOND = 1000
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,   // [12:0] wall_correction
  input  logic        s_axis_tuser_i,   // [0] operation
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o,   // [15:0] left_period, [31:16] right_period,
                                        // [32] left_dir, [33] right_dir, [34] moving
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i
);

  tpsr_pkg::cfg_t cfg_q;
  tpsr_pkg::res_t res, out_q;
  logic           idle, res_valid, res_ready, out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.accel          <= tpsr_pkg::RST_ACCEL;
      cfg_q.start_speed    <= tpsr_pkg::RST_START;
      cfg_q.max_speed      <= tpsr_pkg::RST_MAX;
      cfg_q.end_speed      <= tpsr_pkg::RST_END;
      cfg_q.distance       <= tpsr_pkg::RST_DISTANCE;
      cfg_q.motion_mode    <= tpsr_pkg::RST_MODE;
      cfg_q.centre_speed   <= tpsr_pkg::RST_CENTRE;
      cfg_q.wheel_diameter <= tpsr_pkg::RST_DIAMETER;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        tpsr_pkg::REG_ACCEL:    cfg_q.accel          <= cfg_wdata_i;
        tpsr_pkg::REG_START:    cfg_q.start_speed    <= cfg_wdata_i[11:0];
        tpsr_pkg::REG_MAX:      cfg_q.max_speed      <= cfg_wdata_i[11:0];
        tpsr_pkg::REG_END:      cfg_q.end_speed      <= cfg_wdata_i[11:0];
        tpsr_pkg::REG_DISTANCE: cfg_q.distance       <= cfg_wdata_i;
        tpsr_pkg::REG_MODE:     cfg_q.motion_mode    <= cfg_wdata_i[2:0];
        tpsr_pkg::REG_CENTRE:   cfg_q.centre_speed   <= cfg_wdata_i[11:0];
        tpsr_pkg::REG_DIAMETER: cfg_q.wheel_diameter <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  tpsr_seq #(
    .TREAD_WIDTH      (TREAD_WIDTH),
    .TICKS_PER_SECOND (TICKS_PER_SECOND)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .start_i     (s_axis_tvalid_i && idle),
    .op_i        (s_axis_tuser_i),
    .wall_i      ($signed(s_axis_tdata_i[12:0])),
    .idle_o      (idle),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  assign res_ready = !out_valid_q || m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (res_ready) out_valid_q <= res_valid;
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) out_q <= res;
  end

  assign s_axis_tready_o = idle;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {5'b0, out_q};

endmodule

// File: hdl/tpsr_serdiv.sv
// Unsigned restoring divider, one quotient bit per cycle.
// Standalone; used by tpsr_seq.
module tpsr_serdiv #(
  parameter int unsigned W = 64
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [W-1:0] dividend_i,
  input  logic [W-1:0] divisor_i,
  output logic         done_o,
  output logic [W-1:0] quotient_o
);

  localparam int unsigned CW = $clog2(W);

  logic [W-1:0]  quo_q, dvs_q;
  logic [W:0]    rem_q, rem_sh, rem_sub;
  logic [CW-1:0] cnt_q;
  logic          busy_q, done_q, fits;

  assign rem_sh  = {rem_q[W-1:0], quo_q[W-1]};
  assign fits    = rem_sh >= {1'b0, dvs_q};
  assign rem_sub = rem_sh - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == CW'(W - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      rem_q <= fits ? rem_sub : rem_sh;
      quo_q <= {quo_q[W-2:0], fits};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// File: hdl/tpsr_seq.sv
// Profile sequencer: move setup, profile ticks and wheel periods.
// Depends on tpsr_pkg and tpsr_serdiv.
module tpsr_seq #(
  parameter int unsigned TREAD_WIDTH      = 84,
  parameter int unsigned TICKS_PER_SECOND = 1000
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  tpsr_pkg::cfg_t     cfg_i,
  input  logic               start_i,
  input  logic               op_i,
  input  logic signed [12:0] wall_i,
  output logic               idle_o,
  output logic               res_valid_o,
  input  logic               res_ready_i,
  output tpsr_pkg::res_t     res_o
);

  localparam logic [4:0] ST_IDLE  = 5'd0;
  localparam logic [4:0] ST_CVT   = 5'd1;
  localparam logic [4:0] ST_CVTD  = 5'd2;
  localparam logic [4:0] ST_CVTS  = 5'd3;
  localparam logic [4:0] ST_STEP  = 5'd4;
  localparam logic [4:0] ST_SQ1   = 5'd5;
  localparam logic [4:0] ST_SQ2   = 5'd6;
  localparam logic [4:0] ST_NUM   = 5'd7;
  localparam logic [4:0] ST_BRK   = 5'd8;
  localparam logic [4:0] ST_INIT  = 5'd9;
  localparam logic [4:0] ST_TICK  = 5'd10;
  localparam logic [4:0] ST_ADV   = 5'd11;
  localparam logic [4:0] ST_WHEEL = 5'd12;
  localparam logic [4:0] ST_HALF  = 5'd13;
  localparam logic [4:0] ST_PNUM  = 5'd14;
  localparam logic [4:0] ST_PR    = 5'd15;
  localparam logic [4:0] ST_PL    = 5'd16;
  localparam logic [4:0] ST_PF    = 5'd17;
  localparam logic [4:0] ST_DONE  = 5'd18;
  localparam logic [4:0] ST_DIVW  = 5'd19;

  localparam int unsigned DW = tpsr_pkg::DIV_W;

  logic [4:0]  state_q, state_d, ret_q;
  logic [2:0]  k_q;
  logic [31:0] qv_q [5];
  logic [31:0] step_q, pos_q;
  logic signed [31:0] speed_q, brake_q;
  logic [63:0] sqa_q, prod_q;
  logic        neg_q, active_q, turn_q, wallm_q, back_q, rsgn_q, lway_q, rway_q, qr_ok_q;
  logic signed [12:0] wallc_q;
  logic [1:0]  phase_q;
  logic signed [41:0] rw_q, lw_q;
  logic [15:0] lcnt_q, rcnt_q, qr_q;

  logic          mul_en;
  logic [31:0]   mul_a, mul_b;
  logic          div_go, div_done;
  logic [DW-1:0] div_dvd, div_dvs, div_quo;

  logic [31:0] cvt_v, spd_mag;
  logic signed [33:0] togo;
  logic        far, below_max, above_end;
  logic signed [64:0] num;
  logic        num_neg;
  logic [63:0] num_mag;
  logic [41:0] r_mag, l_mag;
  logic signed [33:0] pos_n;
  logic signed [32:0] spd_n;
  logic signed [41:0] spd42, w42, g42, h42, half, r_t, l_t, r_n, l_n;
  logic        ql_ok;

  tpsr_serdiv #(.W(DW)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_go),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  always_comb begin
    unique case (k_q)
      3'd0:    cvt_v = {16'b0, cfg_i.accel};
      3'd1:    cvt_v = {20'b0, cfg_i.start_speed};
      3'd2:    cvt_v = {20'b0, cfg_i.max_speed};
      3'd3:    cvt_v = {20'b0, cfg_i.end_speed};
      3'd4:    cvt_v = {16'b0, cfg_i.distance};
      default: cvt_v = '0;
    endcase
  end

  assign spd_mag   = speed_q[31] ? 32'(-speed_q) : 32'(speed_q);
  assign togo      = $signed({2'b0, qv_q[4]}) - $signed({2'b0, pos_q});
  assign far       = togo > $signed({{2{brake_q[31]}}, brake_q});
  assign below_max = $signed({speed_q[31], speed_q}) < $signed({1'b0, qv_q[2]});
  assign above_end = $signed({speed_q[31], speed_q}) > $signed({1'b0, qv_q[3]});

  assign num     = $signed({1'b0, sqa_q}) - $signed({1'b0, prod_q});
  assign num_neg = num[64];
  assign num_mag = num_neg ? 64'(-num) : num[63:0];

  assign r_mag = rw_q[41] ? 42'(-rw_q) : 42'(rw_q);
  assign l_mag = lw_q[41] ? 42'(-lw_q) : 42'(lw_q);

  assign pos_n = $signed({2'b0, pos_q})
               + (speed_q[31] ? -$signed({2'b0, div_quo[31:0]})
                              :  $signed({2'b0, div_quo[31:0]}));
  assign spd_n = (phase_q == tpsr_pkg::PH_BRAKE)
               ? $signed({speed_q[31], speed_q}) - $signed({1'b0, step_q})
               : $signed({speed_q[31], speed_q}) + $signed({1'b0, step_q});

  assign spd42 = {{10{speed_q[31]}}, speed_q};
  assign w42   = wallm_q ? {{13{wallc_q[12]}}, wallc_q, 16'b0} : '0;
  assign g42   = {14'b0, cfg_i.centre_speed, 16'b0};
  assign h42   = {3'b0, prod_q[39:1]};
  assign half  = (speed_q[31] ^ rsgn_q) ? -h42 : h42;
  assign r_t   = g42 + half;
  assign l_t   = g42 - half;
  assign r_n   = spd42 - w42;
  assign l_n   = spd42 + w42;
  assign ql_ok = (div_quo[63:16] == '0) && (div_quo[15:0] != tpsr_pkg::PERIOD_LIM);

  always_comb begin
    state_d = state_q;
    mul_en  = 1'b0;
    mul_a   = '0;
    mul_b   = '0;
    div_go  = 1'b0;
    div_dvd = '0;
    div_dvs = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          if (op_i) state_d = ST_CVT;
          else if (active_q) state_d = ST_TICK;
          else state_d = ST_DONE;
        end
      end
      ST_CVT: begin
        if (turn_q) begin
          mul_en  = 1'b1;
          mul_a   = cvt_v;
          mul_b   = tpsr_pkg::TURN_MUL;
          state_d = ST_CVTD;
        end else if (k_q == 3'd4) begin
          state_d = ST_STEP;
        end
      end
      ST_CVTD: begin
        div_go  = 1'b1;
        div_dvd = prod_q + tpsr_pkg::TURN_ROUND;
        div_dvs = tpsr_pkg::TURN_DIV;
        state_d = ST_DIVW;
      end
      ST_CVTS: state_d = (k_q == 3'd4) ? ST_STEP : ST_CVT;
      ST_STEP: begin
        div_go  = 1'b1;
        div_dvd = {32'b0, qv_q[0]};
        div_dvs = DW'(TICKS_PER_SECOND);
        state_d = ST_DIVW;
      end
      ST_SQ1: begin
        mul_en  = 1'b1;
        mul_a   = qv_q[2];
        mul_b   = qv_q[2];
        state_d = ST_SQ2;
      end
      ST_SQ2: begin
        mul_en  = 1'b1;
        mul_a   = qv_q[3];
        mul_b   = qv_q[3];
        state_d = ST_NUM;
      end
      ST_NUM: begin
        if (qv_q[0] == '0) begin
          state_d = ST_INIT;
        end else begin
          div_go  = 1'b1;
          div_dvd = num_mag;
          div_dvs = {31'b0, qv_q[0], 1'b0};
          state_d = ST_DIVW;
        end
      end
      ST_BRK:  state_d = ST_INIT;
      ST_INIT: state_d = ST_DONE;
      ST_TICK: begin
        if (far || above_end) begin
          div_go  = 1'b1;
          div_dvd = {32'b0, spd_mag};
          div_dvs = DW'(TICKS_PER_SECOND);
          state_d = ST_DIVW;
        end else begin
          state_d = ST_WHEEL;
        end
      end
      ST_ADV: state_d = ST_WHEEL;
      ST_WHEEL: begin
        if (turn_q) begin
          mul_en  = 1'b1;
          mul_a   = 32'(TREAD_WIDTH);
          mul_b   = spd_mag;
          state_d = ST_HALF;
        end else begin
          state_d = ST_PNUM;
        end
      end
      ST_HALF: state_d = ST_PNUM;
      ST_PNUM: begin
        mul_en  = 1'b1;
        mul_a   = tpsr_pkg::PERIOD_K;
        mul_b   = {16'b0, cfg_i.wheel_diameter};
        state_d = ST_PR;
      end
      ST_PR: begin
        if (r_mag == '0 || l_mag == '0) begin
          state_d = ST_DONE;
        end else begin
          div_go  = 1'b1;
          div_dvd = {prod_q[47:0], 16'b0};
          div_dvs = {21'b0, r_mag, 1'b0};
          state_d = ST_DIVW;
        end
      end
      ST_PL: begin
        div_go  = 1'b1;
        div_dvd = {prod_q[47:0], 16'b0};
        div_dvs = {21'b0, l_mag, 1'b0};
        state_d = ST_DIVW;
      end
      ST_PF:   state_d = ST_DONE;
      ST_DONE: if (res_ready_i) state_d = ST_IDLE;
      ST_DIVW: if (div_done) state_d = ret_q;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      ret_q    <= ST_IDLE;
      k_q      <= '0;
      active_q <= 1'b0;
      pos_q    <= '0;
      speed_q  <= '0;
      brake_q  <= '0;
      lcnt_q   <= tpsr_pkg::PERIOD_START;
      rcnt_q   <= tpsr_pkg::PERIOD_START;
      lway_q   <= 1'b0;
      rway_q   <= 1'b0;
      turn_q   <= 1'b0;
      wallm_q  <= 1'b0;
      back_q   <= 1'b0;
      rsgn_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      unique case (state_q)
        ST_IDLE: begin
          if (start_i && op_i) begin
            k_q     <= '0;
            turn_q  <= cfg_i.motion_mode == tpsr_pkg::MODE_TURN_L
                    || cfg_i.motion_mode == tpsr_pkg::MODE_TURN_R;
            wallm_q <= cfg_i.motion_mode == tpsr_pkg::MODE_FWD_WALL
                    || cfg_i.motion_mode == tpsr_pkg::MODE_BACK_WALL;
            back_q  <= cfg_i.motion_mode == tpsr_pkg::MODE_BACK
                    || cfg_i.motion_mode == tpsr_pkg::MODE_BACK_WALL;
            rsgn_q  <= cfg_i.motion_mode == tpsr_pkg::MODE_TURN_R;
          end
        end
        ST_CVT:  if (!turn_q && k_q != 3'd4) k_q <= k_q + 1'b1;
        ST_CVTD: ret_q <= ST_CVTS;
        ST_CVTS: if (k_q != 3'd4) k_q <= k_q + 1'b1;
        ST_STEP: ret_q <= ST_SQ1;
        ST_NUM: begin
          ret_q <= ST_BRK;
          if (qv_q[0] == '0) brake_q <= num_neg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end
        ST_BRK: begin
          if (neg_q) begin
            if (div_quo[63:32] != '0 || (div_quo[31] && div_quo[30:0] != '0))
              brake_q <= 32'sh8000_0000;
            else
              brake_q <= $signed(32'(-div_quo[31:0]));
          end else begin
            if (div_quo[63:31] != '0) brake_q <= 32'sh7FFF_FFFF;
            else brake_q <= $signed(div_quo[31:0]);
          end
        end
        ST_INIT: begin
          speed_q  <= $signed(qv_q[1]);
          pos_q    <= '0;
          active_q <= 1'b1;
          lcnt_q   <= tpsr_pkg::PERIOD_START;
          rcnt_q   <= tpsr_pkg::PERIOD_START;
        end
        ST_TICK: begin
          ret_q <= ST_ADV;
          if (!(far || above_end)) active_q <= 1'b0;
        end
        ST_ADV: begin
          if (pos_n[33]) pos_q <= '0;
          else if (pos_n[32]) pos_q <= '1;
          else pos_q <= pos_n[31:0];
          if (phase_q != tpsr_pkg::PH_CRUISE) begin
            if (spd_n[32] != spd_n[31])
              speed_q <= spd_n[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
            else
              speed_q <= spd_n[31:0];
          end
        end
        ST_WHEEL: begin
          if (!turn_q) begin
            rway_q <= back_q ? 1'b1 : r_n[41];
            lway_q <= back_q ? 1'b0 : !l_n[41];
          end
        end
        ST_HALF: begin
          rway_q <= r_t[41];
          lway_q <= !l_t[41];
        end
        ST_PR: begin
          ret_q <= ST_PL;
          if (r_mag == '0 || l_mag == '0) begin
            lcnt_q <= tpsr_pkg::PERIOD_SLOW;
            rcnt_q <= tpsr_pkg::PERIOD_SLOW;
          end
        end
        ST_PL: ret_q <= ST_PF;
        ST_PF: begin
          if (qr_ok_q && ql_ok) begin
            rcnt_q <= qr_q;
            lcnt_q <= div_quo[15:0];
          end else begin
            rcnt_q <= tpsr_pkg::PERIOD_SLOW;
            lcnt_q <= tpsr_pkg::PERIOD_SLOW;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (mul_en) prod_q <= 64'(mul_a) * 64'(mul_b);
    if (state_q == ST_IDLE && start_i) wallc_q <= wall_i;
    if (state_q == ST_CVT && !turn_q) qv_q[k_q] <= {cvt_v[15:0], 16'b0};
    if (state_q == ST_CVTS) qv_q[k_q] <= div_quo[31:0];
    if (state_q == ST_SQ1) step_q <= div_quo[31:0];
    if (state_q == ST_SQ2) sqa_q <= prod_q;
    if (state_q == ST_NUM) neg_q <= num_neg;
    if (state_q == ST_TICK) begin
      if (below_max && far) phase_q <= tpsr_pkg::PH_ACCEL;
      else if (far) phase_q <= tpsr_pkg::PH_CRUISE;
      else phase_q <= tpsr_pkg::PH_BRAKE;
    end
    if (state_q == ST_WHEEL && !turn_q) begin
      rw_q <= r_n;
      lw_q <= l_n;
    end
    if (state_q == ST_HALF) begin
      rw_q <= r_t;
      lw_q <= l_t;
    end
    if (state_q == ST_PL) begin
      qr_q    <= div_quo[15:0];
      qr_ok_q <= ql_ok;
    end
  end

  assign idle_o      = state_q == ST_IDLE;
  assign res_valid_o = state_q == ST_DONE;
  assign res_o       = '{moving: active_q, right_dir: rway_q, left_dir: lway_q,
                         right_period: rcnt_q, left_period: lcnt_q};

endmodule

// File: hdl/tpsr_checker.sv
// Port-level checks of the stepper rate unit, bound to the top level.
// Depends only on the top level's ports.
module tpsr_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [39:0] m_axis_tdata_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("output word changed while stalled");

  a_one_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("input taken while a word is in work");

  a_period_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[15:0] != 16'hFFFF && m_axis_tdata_o[31:16] != 16'hFFFF)
    else $error("period out of range");

  a_reset_empty: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !m_axis_tvalid_o)
    else $error("output valid out of reset");

endmodule

bind trapezoid_profile_stepper_rates_unit tpsr_checker u_tpsr_checker (.*);

// File: tb/sv/tb_trapezoid_profile_stepper_rates_unit.sv
// Self-checking bench for trapezoid_profile_stepper_rates_unit: directed and random
// moves and ticks, checked word by word by a bit-exact predictor. Depends on tpsr_pkg.
module tb_trapezoid_profile_stepper_rates_unit;

  localparam int TREAD = 84;
  localparam int TICKS = 1000;
  localparam int WDOG_LIMIT = 30000;

  typedef struct {
    bit               op;
    logic signed [12:0] wall;
  } cmd_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;
  logic        s_tuser = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_idx = '0;
  logic [15:0] cfg_wdata = '0;

  cmd_t pending_cmds[$];
  tpsr_pkg::res_t expected_words[$];
  cmd_t cur_cmd;
  int   send_idle = 8;
  int   recv_idle = 55;
  int   recv_hold = 0;
  int   errors = 0;
  int   stall_cycles = 0;

  // profile state
  logic [15:0]    regs[8];
  longint         position, speed, brake, mv_step, mv_max, mv_end, mv_target, mv_sign;
  bit             active, mv_turn, mv_wall, mv_back;
  logic [15:0]    lcnt, rcnt;
  bit             lway, rway;

  trapezoid_profile_stepper_rates_unit #(.TREAD_WIDTH(TREAD), .TICKS_PER_SECOND(TICKS)) DUT (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid_i(s_tvalid), .s_axis_tready_o(s_tready),
    .s_axis_tdata_i(s_tdata), .s_axis_tuser_i(s_tuser),
    .m_axis_tvalid_o(m_tvalid), .m_axis_tready_i(m_tready), .m_axis_tdata_o(m_tdata),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_wdata_i(cfg_wdata)
  );

  always #5 clk_i = ~clk_i;

  function automatic longint scale_q(longint unsigned v, bit turn);
    if (turn) return longint'((v * 64'd10289152 + 64'd4500) / 64'd9000);
    return longint'(v << 16);
  endfunction

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint wheel_period(longint w, output bit ok);
    longint unsigned mag, q;
    mag = (w < 0) ? longint'(-w) : w;
    if (mag == 0) begin
      ok = 1'b0;
      return 0;
    end
    q = (64'd157 * longint'(regs[tpsr_pkg::REG_DIAMETER]) * 64'd65536) / (64'd2 * mag);
    ok = q < 64'd65535;
    return q;
  endfunction

  function automatic tpsr_pkg::res_t step_profile(cmd_t c);
    tpsr_pkg::res_t res;
    longint aq, num, r, l, half, pr, pl, p;
    bit     far, okr, okl;
    logic [2:0] mode;
    if (c.op) begin
      mode = regs[tpsr_pkg::REG_MODE][2:0];
      mv_turn = (mode == tpsr_pkg::MODE_TURN_L) || (mode == tpsr_pkg::MODE_TURN_R);
      mv_wall = (mode == tpsr_pkg::MODE_FWD_WALL) || (mode == tpsr_pkg::MODE_BACK_WALL);
      mv_back = (mode == tpsr_pkg::MODE_BACK) || (mode == tpsr_pkg::MODE_BACK_WALL);
      mv_sign = (mode == tpsr_pkg::MODE_TURN_R) ? -1 : 1;
      aq = scale_q(regs[tpsr_pkg::REG_ACCEL], mv_turn);
      mv_step = aq / TICKS;
      speed = scale_q(regs[tpsr_pkg::REG_START], mv_turn);
      mv_max = scale_q(regs[tpsr_pkg::REG_MAX], mv_turn);
      mv_end = scale_q(regs[tpsr_pkg::REG_END], mv_turn);
      mv_target = scale_q(regs[tpsr_pkg::REG_DISTANCE], mv_turn);
      num = mv_max * mv_max - mv_end * mv_end;
      if (aq == 0) brake = (num < 0) ? -64'sd2147483648 : 64'sd2147483647;
      else brake = sat32(num / (2 * aq));
      position = 0;
      active = 1'b1;
      lcnt = tpsr_pkg::PERIOD_START;
      rcnt = tpsr_pkg::PERIOD_START;
    end else if (active) begin
      far = (mv_target - position) > brake;
      if (speed < mv_max && far || far || speed > mv_end) begin
        p = position + speed / TICKS;
        if (p < 0) p = 0;
        if (p > 64'sd4294967295) p = 64'sd4294967295;
        position = p;
        if (speed < mv_max && far) speed = sat32(speed + mv_step);
        else if (!far) speed = sat32(speed - mv_step);
      end else begin
        active = 1'b0;
      end
      if (mv_turn) begin
        half = mv_sign * TREAD * speed / 2;
        r = (longint'(regs[tpsr_pkg::REG_CENTRE][11:0]) << 16) + half;
        l = (longint'(regs[tpsr_pkg::REG_CENTRE][11:0]) << 16) - half;
      end else begin
        r = speed;
        l = speed;
        if (mv_wall) begin
          l += longint'(c.wall) * 65536;
          r -= longint'(c.wall) * 65536;
        end
      end
      rway = r < 0;
      lway = !(l < 0);
      if (!mv_turn && mv_back) begin
        rway = 1'b1;
        lway = 1'b0;
      end
      pr = wheel_period(r, okr);
      pl = wheel_period(l, okl);
      if (okr && okl) begin
        rcnt = pr[15:0];
        lcnt = pl[15:0];
      end else begin
        rcnt = tpsr_pkg::PERIOD_SLOW;
        lcnt = tpsr_pkg::PERIOD_SLOW;
      end
    end
    res.left_period = lcnt;
    res.right_period = rcnt;
    res.left_dir = lway;
    res.right_dir = rway;
    res.moving = active;
    return res;
  endfunction

  // driver
  always @(posedge clk_i or negedge rst_ni) begin : drive_words
    bit nxt_valid;
    if (!rst_ni) begin
      s_tvalid <= 1'b0;
    end else begin
      nxt_valid = s_tvalid;
      if (s_tvalid && s_tready) begin
        expected_words.push_back(step_profile(cur_cmd));
        nxt_valid = 1'b0;
      end
      if (!nxt_valid && pending_cmds.size() > 0 && $urandom_range(99) >= send_idle) begin
        cur_cmd = pending_cmds.pop_front();
        s_tdata <= {3'b000, cur_cmd.wall};
        s_tuser <= cur_cmd.op;
        nxt_valid = 1'b1;
      end
      s_tvalid <= nxt_valid;
    end
  end

  // monitor, receiver stalls and watchdog
  always @(posedge clk_i or negedge rst_ni) begin : check_words
    tpsr_pkg::res_t got, want;
    if (!rst_ni) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = tpsr_pkg::res_t'(m_tdata[34:0]);
        if (expected_words.size() == 0) begin
          $error("unexpected word %h", m_tdata);
          errors++;
        end else begin
          want = expected_words.pop_front();
          if (got.left_period !== want.left_period) begin
            $error("left_period exp %0d got %0d", want.left_period, got.left_period); errors++;
          end
          if (got.right_period !== want.right_period) begin
            $error("right_period exp %0d got %0d", want.right_period, got.right_period); errors++;
          end
          if (got.left_dir !== want.left_dir) begin
            $error("left_dir exp %0d got %0d", want.left_dir, got.left_dir); errors++;
          end
          if (got.right_dir !== want.right_dir) begin
            $error("right_dir exp %0d got %0d", want.right_dir, got.right_dir); errors++;
          end
          if (got.moving !== want.moving) begin
            $error("moving exp %0d got %0d", want.moving, got.moving); errors++;
          end
        end
      end
      if ((m_tvalid && m_tready) || (s_tvalid && s_tready) ||
          (expected_words.size() == 0 && pending_cmds.size() == 0 && !s_tvalid)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
        if (stall_cycles >= WDOG_LIMIT) begin
          $display("[trapezoid_profile_stepper_rates_unit] ERROR");
          $finish;
        end
      end
      if (recv_hold > 0) begin
        recv_hold--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= $urandom_range(99) >= recv_idle;
      end
    end
  end

  task automatic wait_idle();
    while (pending_cmds.size() > 0 || expected_words.size() > 0 || s_tvalid)
      @(posedge clk_i);
  endtask

  task automatic load_regs(input logic [15:0] v[8]);
    for (int i = 0; i < 8; i++) begin
      @(posedge clk_i);
      cfg_we <= 1'b1;
      cfg_idx <= i[2:0];
      cfg_wdata <= v[i];
      regs[i] = v[i];
    end
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic push_cmd(bit op, logic signed [12:0] wall);
    cmd_t c;
    c.op = op;
    c.wall = wall;
    pending_cmds.push_back(c);
  endtask

  task automatic run_move(input logic [15:0] v[8], int nticks);
    wait_idle();
    load_regs(v);
    push_cmd(1'b1, 13'($urandom));
    for (int i = 0; i < nticks; i++)
      push_cmd($urandom_range(60) == 0, 13'($urandom));
  endtask

  initial begin : stimulus
    logic [15:0] v[8];
    int sent;
    regs = '{tpsr_pkg::RST_ACCEL, tpsr_pkg::RST_START, tpsr_pkg::RST_MAX,
             tpsr_pkg::RST_END, tpsr_pkg::RST_DISTANCE, tpsr_pkg::RST_MODE,
             tpsr_pkg::RST_CENTRE, tpsr_pkg::RST_DIAMETER};
    position = 0; speed = 0; brake = 0; active = 0;
    mv_step = 0; mv_max = 0; mv_end = 0; mv_target = 0; mv_sign = 0;
    mv_turn = 0; mv_wall = 0; mv_back = 0;
    lcnt = tpsr_pkg::PERIOD_START; rcnt = tpsr_pkg::PERIOD_START; lway = 0; rway = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: idle ticks, wall extremes, wall and turn modes, zero accel, saturating values
    push_cmd(1'b0, -13'sd4096);
    push_cmd(1'b0, 13'sd4095);
    v = '{16'd20000, 16'd100, 16'd400, 16'd50, 16'd3, 16'd1, 16'd0, 16'd51115};
    run_move(v, 4);
    push_cmd(1'b0, -13'sd4096);
    push_cmd(1'b0, 13'sd4095);
    v = '{16'd0, 16'd4095, 16'd0, 16'd4095, 16'd65535, 16'd3, 16'd4095, 16'd1};
    run_move(v, 3);
    v = '{16'd65535, 16'd0, 16'd4095, 16'd0, 16'd0, 16'd4, 16'd4095, 16'd65535};
    run_move(v, 3);
    v = '{16'd9000, 16'd200, 16'd300, 16'd0, 16'd2, 16'd5, 16'd0, 16'd51115};
    run_move(v, 3);
    v = '{16'd50000, 16'd0, 16'd100, 16'd0, 16'd1, 16'd7, 16'd10, 16'd40000};
    run_move(v, 3);

    // random moves over three idling regimes
    sent = 0;
    for (int ph = 0; ph < 3; ph++) begin
      send_idle = (ph == 0) ? 8 : (ph == 1) ? 55 : 0;
      recv_idle = (ph == 0) ? 55 : (ph == 1) ? 8 : 0;
      for (int m = 0; m < 8; m++) begin
        v[tpsr_pkg::REG_ACCEL] = ($urandom_range(9) == 0)
                               ? 16'(($urandom_range(1)) * 65535)
                               : 16'($urandom_range(65535, 1000));
        v[tpsr_pkg::REG_START] = 16'($urandom_range(4095));
        v[tpsr_pkg::REG_MAX] = 16'($urandom_range(4095));
        v[tpsr_pkg::REG_END] = 16'($urandom_range(4095));
        v[tpsr_pkg::REG_DISTANCE] = ($urandom_range(9) == 0) ? 16'($urandom)
                                                             : 16'($urandom_range(20));
        v[tpsr_pkg::REG_MODE] = 16'($urandom_range(7));
        v[tpsr_pkg::REG_CENTRE] = 16'($urandom_range(4095));
        v[tpsr_pkg::REG_DIAMETER] = 16'($urandom_range(65535, 1));
        run_move(v, $urandom_range(45, 10));
        if (ph == 2 && m == 2) recv_hold = 600;
        sent += 1;
      end
    end

    wait_idle();
    repeat (600) @(posedge clk_i);
    if (errors == 0)
      $display("[trapezoid_profile_stepper_rates_unit] OK");
    else
      $display("[trapezoid_profile_stepper_rates_unit] ERROR");
    $finish;
  end

endmodule
